>>> hw/rtl/okd_pkg.sv
// okd_pkg: shared types and codes of the order-preserving key decoder
// no dependencies; used by every file of the decoder

package okd_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
    localparam logic [31:0] SIGN32 = 32'h8000_0000;
    localparam logic [7:0] BYTE_MASK = 8'hff;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_COLUMN_COUNT    = 2'd0,
        CFG_COLUMN_TYPES    = 2'd1,
        CFG_DESCENDING_MASK = 2'd2,
        CFG_NULLS_LAST_MASK = 2'd3
    } t_cfg_index;

    // column type codes
    typedef enum logic [3:0] {
        TY_INT64     = 4'd0,
        TY_INT32     = 4'd1,
        TY_INT16     = 4'd2,
        TY_INT8      = 4'd3,
        TY_DOUBLE    = 4'd4,
        TY_REAL      = 4'd5,
        TY_BOOL      = 4'd6,
        TY_STRING    = 4'd7,
        TY_TIMESTAMP = 4'd8
    } t_col_type;

    typedef enum logic [2:0] {
        RK_NULL       = 3'd0,
        RK_FIXED      = 3'd1,
        RK_TS_SECONDS = 3'd2,
        RK_TS_NANOS   = 3'd3,
        RK_STR_BYTE   = 3'd4,
        RK_STR_END    = 3'd5,
        RK_ERROR      = 3'd6
    } t_result_kind;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_BAD_MARKER  = 3'd1,
        ERR_BAD_BOOL    = 3'd2,
        ERR_BAD_ESCAPE  = 3'd3,
        ERR_ENDED_EARLY = 3'd4,
        ERR_TRAILING    = 3'd5
    } t_err_code;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       key_end;
    } t_key_in;

    typedef struct packed {
        logic [2:0]  column_number;
        logic [2:0]  result_kind;
        logic [63:0] value_bits;
        logic [2:0]  error_code;
        logic        final_of_key;
    } t_result;

    // results caused by one key byte
    typedef struct packed {
        logic    pair;
        t_result first;
        t_result second;
    } t_entry;

endpackage

>>> hw/rtl/okd_front.sv
// okd_front: configuration registers and per-byte decode state machine
// depends on okd_pkg; feeds okd_queue with the results of each byte

module okd_front #(
    parameter int MAX_KEY_COLUMNS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    input  logic             i_accept,
    input  okd_pkg::t_key_in i_key,
    output logic             o_entry_valid,
    output okd_pkg::t_entry  o_entry
);

    localparam int CW = (MAX_KEY_COLUMNS > 8) ? 4 : 3;
    localparam logic [4:0] MAX_COLS = 5'(MAX_KEY_COLUMNS);

    typedef enum logic [1:0] {
        PH_MARKER = 2'd0,
        PH_BODY   = 2'd1,
        PH_ESCAPE = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    logic [3:0]  r_column_count;
    logic [31:0] r_column_types;
    logic [7:0]  r_desc_mask;
    logic [7:0]  r_nulls_last_mask;

    logic [CW-1:0] r_col,   n_col;
    t_phase        r_phase, n_phase;
    logic [4:0]    r_taken, n_taken;
    logic [63:0]   r_acc,   n_acc;
    logic          r_skip,  n_skip;

    logic [4:0]  eff_count;
    logic        last_col;
    logic        col_cfg;
    logic [3:0]  raw_ty;
    okd_pkg::t_col_type ty;
    logic        desc, nl;
    logic [7:0]  d;
    logic [63:0] acc_sh;
    logic [4:0]  taken_inc;
    logic [4:0]  width;
    logic [63:0] fixed_val;
    logic [2:0]  col_out;

    logic                m_v;
    okd_pkg::t_result    m_res;
    okd_pkg::t_err_code  err;
    logic                s_v;
    okd_pkg::t_result    s_res;

    function automatic logic [4:0] type_width(input okd_pkg::t_col_type t);
        unique case (t)
            okd_pkg::TY_INT32, okd_pkg::TY_REAL: type_width = 5'd4;
            okd_pkg::TY_INT16:                   type_width = 5'd2;
            okd_pkg::TY_INT8:                    type_width = 5'd1;
            okd_pkg::TY_TIMESTAMP:               type_width = 5'd16;
            default:                             type_width = 5'd8;
        endcase
    endfunction

    function automatic okd_pkg::t_result mk(input logic [2:0] col, input logic [2:0] kind,
                                            input logic [63:0] val,
                                            input logic [2:0] code, input logic fin);
        okd_pkg::t_result r;
        r.column_number = col;
        r.result_kind   = kind;
        r.value_bits    = val;
        r.error_code    = code;
        r.final_of_key  = fin;
        return r;
    endfunction

    // column count clamped to 1..MAX_KEY_COLUMNS
    always_comb begin
        priority if (r_column_count == 4'd0) begin
            eff_count = 5'd1;
        end else if (5'(r_column_count) > MAX_COLS) begin
            eff_count = MAX_COLS;
        end else begin
            eff_count = 5'(r_column_count);
        end
    end

    assign last_col  = (5'(r_col) + 5'd1) >= eff_count;
    assign col_cfg   = 5'(r_col) < 5'd8;
    assign raw_ty    = col_cfg ? r_column_types[{r_col[2:0], 2'b00} +: 4] : 4'd0;
    assign ty        = (raw_ty > 4'd8) ? okd_pkg::TY_INT64 : okd_pkg::t_col_type'(raw_ty);
    assign desc      = col_cfg & r_desc_mask[r_col[2:0]];
    assign nl        = col_cfg & r_nulls_last_mask[r_col[2:0]];
    assign d         = desc ? (i_key.key_byte ^ okd_pkg::BYTE_MASK) : i_key.key_byte;
    assign acc_sh    = {r_acc[55:0], d};
    assign taken_inc = r_taken + 5'd1;
    assign width     = type_width(ty);
    assign col_out   = r_col[2:0];

    // finished fixed-width value, order transform undone
    always_comb begin
        unique case (ty)
            okd_pkg::TY_DOUBLE:
                fixed_val = acc_sh[63] ? (acc_sh ^ okd_pkg::SIGN64) : ~acc_sh;
            okd_pkg::TY_REAL:
                fixed_val = acc_sh[31] ? {32'd0, acc_sh[31:0] ^ okd_pkg::SIGN32}
                                       : {32'd0, ~acc_sh[31:0]};
            okd_pkg::TY_INT32:
                fixed_val = {{32{~acc_sh[31]}}, ~acc_sh[31], acc_sh[30:0]};
            okd_pkg::TY_INT16:
                fixed_val = {{48{~acc_sh[15]}}, ~acc_sh[15], acc_sh[14:0]};
            okd_pkg::TY_INT8:
                fixed_val = {{56{~acc_sh[7]}}, ~acc_sh[7], acc_sh[6:0]};
            okd_pkg::TY_TIMESTAMP:
                fixed_val = acc_sh;
            default:
                fixed_val = acc_sh ^ okd_pkg::SIGN64;
        endcase
    end

    always_comb begin
        n_col   = r_col;
        n_phase = r_phase;
        n_taken = r_taken;
        n_acc   = r_acc;
        n_skip  = r_skip;
        m_v     = 1'b0;
        m_res   = mk(col_out, okd_pkg::RK_NULL, 64'd0, okd_pkg::ERR_NONE, 1'b0);
        err     = okd_pkg::ERR_NONE;
        s_v     = 1'b0;
        s_res   = mk(col_out, okd_pkg::RK_ERROR, 64'd0, okd_pkg::ERR_NONE, 1'b1);

        if (!r_skip) begin
            unique case (r_phase)
                PH_MARKER: begin
                    if (i_key.key_byte == {7'd0, nl}) begin
                        m_v = 1'b1;
                        if (last_col) n_phase = PH_DONE;
                        else begin
                            n_col   = r_col + CW'(1);
                            n_phase = PH_MARKER;
                        end
                        n_taken = '0;
                        n_acc   = '0;
                    end else if (i_key.key_byte == {7'd0, ~nl}) begin
                        n_phase = PH_BODY;
                        n_taken = '0;
                        n_acc   = '0;
                    end else begin
                        err = okd_pkg::ERR_BAD_MARKER;
                    end
                end
                PH_BODY: begin
                    if (ty == okd_pkg::TY_STRING) begin
                        if (d == 8'd0) begin
                            m_v   = 1'b1;
                            m_res = mk(col_out, okd_pkg::RK_STR_END, 64'd0,
                                       okd_pkg::ERR_NONE, 1'b0);
                            if (last_col) n_phase = PH_DONE;
                            else begin
                                n_col   = r_col + CW'(1);
                                n_phase = PH_MARKER;
                            end
                            n_taken = '0;
                            n_acc   = '0;
                        end else if (d == 8'd1) begin
                            n_phase = PH_ESCAPE;
                        end else begin
                            m_v   = 1'b1;
                            m_res = mk(col_out, okd_pkg::RK_STR_BYTE, {56'd0, d},
                                       okd_pkg::ERR_NONE, 1'b0);
                        end
                    end else if (ty == okd_pkg::TY_BOOL) begin
                        if (d == 8'd1 || d == 8'd2) begin
                            m_v   = 1'b1;
                            m_res = mk(col_out, okd_pkg::RK_FIXED, {63'd0, d == 8'd2},
                                       okd_pkg::ERR_NONE, 1'b0);
                            if (last_col) n_phase = PH_DONE;
                            else begin
                                n_col   = r_col + CW'(1);
                                n_phase = PH_MARKER;
                            end
                            n_taken = '0;
                            n_acc   = '0;
                        end else begin
                            err = okd_pkg::ERR_BAD_BOOL;
                        end
                    end else begin
                        n_acc   = acc_sh;
                        n_taken = taken_inc;
                        // seconds word of a timestamp is done halfway
                        if (ty == okd_pkg::TY_TIMESTAMP && taken_inc == 5'd8) begin
                            m_v   = 1'b1;
                            m_res = mk(col_out, okd_pkg::RK_TS_SECONDS,
                                       acc_sh ^ okd_pkg::SIGN64, okd_pkg::ERR_NONE, 1'b0);
                        end else if (taken_inc >= width) begin
                            m_v   = 1'b1;
                            m_res = mk(col_out,
                                       (ty == okd_pkg::TY_TIMESTAMP) ? okd_pkg::RK_TS_NANOS
                                                                     : okd_pkg::RK_FIXED,
                                       fixed_val, okd_pkg::ERR_NONE, 1'b0);
                            if (last_col) n_phase = PH_DONE;
                            else begin
                                n_col   = r_col + CW'(1);
                                n_phase = PH_MARKER;
                            end
                            n_taken = '0;
                            n_acc   = '0;
                        end
                    end
                end
                PH_ESCAPE: begin
                    if (d == 8'd0 || d == 8'd1) begin
                        m_v     = 1'b1;
                        m_res   = mk(col_out, okd_pkg::RK_STR_BYTE, {56'd0, d},
                                     okd_pkg::ERR_NONE, 1'b0);
                        n_phase = PH_BODY;
                    end else begin
                        err = okd_pkg::ERR_BAD_ESCAPE;
                    end
                end
                default: begin
                    err = okd_pkg::ERR_TRAILING;
                end
            endcase

            if (err != okd_pkg::ERR_NONE) begin
                s_v   = 1'b1;
                s_res = mk(col_out, okd_pkg::RK_ERROR, 64'd0, err, 1'b1);
                n_skip = 1'b1;
            end else if (i_key.key_end) begin
                if (n_phase != PH_DONE) begin
                    s_v   = 1'b1;
                    s_res = mk(n_col[2:0], okd_pkg::RK_ERROR, 64'd0,
                               okd_pkg::ERR_ENDED_EARLY, 1'b1);
                end else begin
                    m_res.final_of_key = 1'b1;
                end
            end
        end

        // end of key starts the next one from column zero
        if (i_key.key_end) begin
            n_col   = '0;
            n_phase = PH_MARKER;
            n_taken = '0;
            n_acc   = '0;
            n_skip  = 1'b0;
        end
    end

    assign o_entry_valid = i_accept & (m_v | s_v);
    assign o_entry.pair   = m_v & s_v;
    assign o_entry.first  = m_v ? m_res : s_res;
    assign o_entry.second = s_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count    <= 4'd1;
            r_column_types    <= '0;
            r_desc_mask       <= '0;
            r_nulls_last_mask <= '0;
            r_col             <= '0;
            r_phase           <= PH_MARKER;
            r_taken           <= '0;
            r_acc             <= '0;
            r_skip            <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (okd_pkg::t_cfg_index'(i_cfg_index))
                    okd_pkg::CFG_COLUMN_COUNT:    r_column_count    <= i_cfg_data[3:0];
                    okd_pkg::CFG_COLUMN_TYPES:    r_column_types    <= i_cfg_data;
                    okd_pkg::CFG_DESCENDING_MASK: r_desc_mask       <= i_cfg_data[7:0];
                    okd_pkg::CFG_NULLS_LAST_MASK: r_nulls_last_mask <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_col   <= n_col;
                r_phase <= n_phase;
                r_taken <= n_taken;
                r_acc   <= n_acc;
                r_skip  <= n_skip;
            end
        end
    end

endmodule

>>> hw/rtl/okd_queue.sv
// okd_queue: short queue of per-byte result entries between front and back
// depends on okd_pkg

module okd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_enq,
    input  okd_pkg::t_entry i_entry,
    input  logic            i_deq,
    output okd_pkg::t_entry o_head,
    output logic            o_full,
    output logic            o_empty
);

    localparam int AW = $clog2(okd_pkg::QUEUE_DEPTH);
    localparam logic [AW:0] DEPTH_CNT = (AW + 1)'(okd_pkg::QUEUE_DEPTH);

    okd_pkg::t_entry r_mem [okd_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [AW:0]     r_count;

    assign o_full  = r_count == DEPTH_CNT;
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_enq) r_mem[r_wr_ptr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_enq) r_wr_ptr <= r_wr_ptr + AW'(1);
            if (i_deq) r_rd_ptr <= r_rd_ptr + AW'(1);
            unique case ({i_enq, i_deq})
                2'b10:   r_count <= r_count + (AW + 1)'(1);
                2'b01:   r_count <= r_count - (AW + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hw/rtl/okd_back.sv
// okd_back: hands out the results of each queued entry one request at a time
// depends on okd_pkg; reads the head of okd_queue

module okd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  okd_pkg::t_entry  i_head,
    input  logic             i_q_empty,
    input  logic             i_pop,
    output logic             o_deq,
    output logic             o_empty,
    output okd_pkg::t_result o_result
);

    logic r_second;
    logic take;

    assign take     = i_pop & ~i_q_empty;
    assign o_empty  = i_q_empty;
    assign o_result = r_second ? i_head.second : i_head.first;
    assign o_deq    = take & (r_second | ~i_head.pair);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else if (take) begin
            r_second <= ~r_second & i_head.pair;
        end
    end

endmodule

>>> hw/rtl/order_preserving_key_decoder.sv
// order_preserving_key_decoder: top level of the sort key decoder
// depends on okd_pkg, okd_front, okd_queue and okd_back

// Decodes order-preserving sort keys one byte per request. Each key holds
// column_count columns; every column opens with a null marker byte, and its
// body follows by the column's type (big-endian integers, doubles, reals,
// booleans, 16-byte timestamps, zero-terminated strings with escape byte 1),
// with descending columns inverted. Results come out oldest first: null
// markers, values, string bytes and string ends, and error results with
// final_of_key set; after an error the rest of the key is dropped up to the
// byte that carries key_end. Rate: a byte is taken every cycle while full is
// low; the decode state machine settles one byte per cycle. Each byte that
// yields results puts one entry into a four-entry queue, and the result side
// pops one result per cycle while empty is low, so a byte with two results (a
// value plus a key ended early error) holds the queue head for two pops. A
// result is queued when its byte is taken. The user must write configuration
// only while no key is in flight; the block does not enforce it. A write
// applies from the next byte; reset clears decode state, configuration, queue.

module order_preserving_key_decoder #(
    parameter int MAX_KEY_COLUMNS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration write port
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    // key byte requests
    input  logic             push,
    output logic             full,
    input  okd_pkg::t_key_in i_key,
    // result requests
    output logic             empty,
    input  logic             pop,
    output okd_pkg::t_result o_result
);

    logic            accept;
    logic            enq;
    okd_pkg::t_entry entry;
    okd_pkg::t_entry head;
    logic            q_empty;
    logic            deq;

    // a byte is taken whenever the queue has room, even with results waiting
    assign accept = push & ~full;

    okd_front #(
        .MAX_KEY_COLUMNS(MAX_KEY_COLUMNS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_key        (i_key),
        .o_entry_valid(enq),
        .o_entry      (entry)
    );

    // decouples byte intake from result delivery
    okd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_enq  (enq),
        .i_entry(entry),
        .i_deq  (deq),
        .o_head (head),
        .o_full (full),
        .o_empty(q_empty)
    );

    // splits two-result entries into single pops
    okd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_empty(q_empty),
        .i_pop    (pop),
        .o_deq    (deq),
        .o_empty  (empty),
        .o_result (o_result)
    );

endmodule

>>> hw/rtl/okd_checker.sv
// okd_checker: port-level assertions for the sort key decoder
// depends on okd_pkg; bound to order_preserving_key_decoder

module okd_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input okd_pkg::t_result o_result
);

    // every error result closes its key
    a_error_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.result_kind == okd_pkg::RK_ERROR) |-> o_result.final_of_key)
        else $error("error result without final_of_key");

    // an error code travels only with an error result
    a_code_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_result.error_code != okd_pkg::ERR_NONE) ==
                    (o_result.result_kind == okd_pkg::RK_ERROR)))
        else $error("error code and result kind disagree");

    // string bytes are single bytes
    a_str_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.result_kind == okd_pkg::RK_STR_BYTE)
        |-> (o_result.value_bits[63:8] == 56'd0))
        else $error("string byte wider than eight bits");

    // a waiting result stays until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed before pop");

    // reset leaves the block with nothing pending and room for bytes
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> (empty && !full))
        else $error("queue not clear after reset");

endmodule

bind order_preserving_key_decoder okd_checker u_okd_checker (.*);
